### rtl/core/tiht_pkg.sv
package tiht_pkg;

	localparam int TICK_W = 32;

	localparam logic [2:0] KIND_PUT     = 3'd0;
	localparam logic [2:0] KIND_GET     = 3'd1;
	localparam logic [2:0] KIND_HOLD    = 3'd2;
	localparam logic [2:0] KIND_IDLE    = 3'd3;
	localparam logic [2:0] KIND_PROMOTE = 3'd4;

	localparam logic [15:0] IDLE_BUTTONS = 16'hFFFF;

	typedef struct packed {
		logic [2:0]        kind;
		logic [2:0]        slot;
		logic [31:0]       tick;
		logic [15:0]       buttons;
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
		logic              analog;
		logic              predicted;
		logic              frame_valid;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [31:0]       out_tick;
		logic [15:0]       out_buttons;
		logic signed [7:0] out_stick_x;
		logic signed [7:0] out_stick_y;
		logic              out_analog;
		logic              out_predicted;
		logic [31:0]       invents_done;
		logic [31:0]       promotes_done;
	} rsp_t;

	typedef struct packed {
		logic              predicted;
		logic              analog;
		logic signed [7:0] stick_y;
		logic signed [7:0] stick_x;
		logic [15:0]       buttons;
	} payload_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] tag;
		payload_t    payload;
	} entry_t;

	typedef struct packed {
		logic [31:0] diff;
		logic        borrow;
		logic        eq;
	} alu_res_t;

	localparam payload_t IDLE_PAYLOAD = '{
		predicted: 1'b1,
		analog:    1'b0,
		stick_y:   8'sd0,
		stick_x:   8'sd0,
		buttons:   IDLE_BUTTONS
	};

endpackage

### rtl/core/tiht_alu.sv
module tiht_alu (
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output tiht_pkg::alu_res_t res
);
	import tiht_pkg::*;

	logic [32:0] sub;

	assign sub        = {1'b0, a} - {1'b0, b};
	assign res.diff   = sub[31:0];
	assign res.borrow = sub[32];
	assign res.eq     = (a == b);

endmodule

### rtl/core/tiht_table.sv
module tiht_table #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                clk,
	input  logic                en,
	input  logic                we,
	input  logic [AW-1:0]       addr,
	input  tiht_pkg::entry_t    wdata,
	output tiht_pkg::entry_t    rdata
);
	import tiht_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### rtl/core/tagged_input_history_table_unit.sv
// Per-slot history of controller frames, one ring of HIST_DEPTH entries per slot, indexed
// by tick modulo HIST_DEPTH and tagged with the full tick. After reset the block clears its
// table and takes no request meanwhile; configuration beats are taken at any time. One
// request is worked at a time through a single-port table memory and one shared 32-bit
// subtractor. A rejected request goes straight to its result; put, promote and invent idle
// write the table once; get reads and checks one entry; invent hold-last probes earlier
// ticks one by one until a probe hits, HIST_DEPTH-1 probes have missed or tick 0 is
// reached, and then writes. When HIST_DEPTH is not a power of two, a reciprocal multiply and
// one subtraction find the ring position of every request that is not rejected. The next
// request is accepted while a finished result still waits on the response channel.
module tagged_input_history_table_unit #(
	parameter int HIST_DEPTH = 32,
	parameter int MAX_SLOTS  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tiht_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tiht_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [3:0]     cfg_data
);
	import tiht_pkg::*;

	localparam int TABLE = MAX_SLOTS * HIST_DEPTH;
	localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1;
	localparam int RW    = $clog2(HIST_DEPTH);
	localparam int RS    = TICK_W + RW;
	localparam logic [32:0] RECIP =
		33'(((64'd1 << RS) + 64'(HIST_DEPTH - 1)) / 64'(HIST_DEPTH));
	localparam bit DEPTH_POW2 = (HIST_DEPTH & (HIST_DEPTH - 1)) == 0;

	localparam logic [3:0] ST_CLEAR    = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_MOD      = 4'd2;
	localparam logic [3:0] ST_DISPATCH = 4'd3;
	localparam logic [3:0] ST_RD       = 4'd4;
	localparam logic [3:0] ST_CHK      = 4'd5;
	localparam logic [3:0] ST_STEP     = 4'd6;
	localparam logic [3:0] ST_WR       = 4'd7;
	localparam logic [3:0] ST_DONE     = 4'd8;
	localparam logic [3:0] ST_MODSUB   = 4'd9;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [3:0]    slot_count_q;
	logic [31:0]   invent_total_q;
	logic [31:0]   promote_total_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	req_t          item_q;
	logic [AW-1:0] base_q;
	logic [RW-1:0] idx0_q;
	logic [RW-1:0] idx_q;
	logic [RW-1:0] back_q;
	logic [31:0]   quot_q;
	logic [31:0]   cur_q;
	payload_t      pay_q;
	logic          res_ok_q;
	logic          res_show_q;

	logic          accept;
	logic          reject;
	logic          rsp_load;
	logic [65:0]   recip_prod;
	logic [31:0]   quot_mul;
	logic [31:0]   alu_a;
	logic [31:0]   alu_b;
	alu_res_t      alu;
	logic          tbl_en;
	logic          tbl_we;
	logic [AW-1:0] tbl_addr;
	entry_t        tbl_wdata;
	entry_t        tbl_rdata;
	logic          hit;
	logic [3:0]    cfg_sat;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	assign reject = ({1'b0, req.slot} >= slot_count_q) || (req.kind > KIND_PROMOTE) ||
		(((req.kind == KIND_PUT) || (req.kind == KIND_PROMOTE)) && !req.frame_valid);

	assign recip_prod = 66'(item_q.tick) * 66'(RECIP);
	assign quot_mul   = quot_q * 32'(HIST_DEPTH);
	assign hit        = tbl_rdata.valid && alu.eq;

	always_comb begin
		if (cfg_data == 4'd0) begin
			cfg_sat = 4'd1;
		end else if ({1'b0, cfg_data} > 5'(MAX_SLOTS)) begin
			cfg_sat = 4'(MAX_SLOTS);
		end else begin
			cfg_sat = cfg_data;
		end
	end

	always_comb begin
		case (state_q)
			ST_MODSUB: begin
				alu_a = item_q.tick;
				alu_b = quot_mul;
			end
			ST_STEP: begin
				alu_a = cur_q;
				alu_b = 32'd1;
			end
			ST_CHK: begin
				alu_a = tbl_rdata.tag;
				alu_b = cur_q;
			end
			default: begin
				alu_a = cur_q;
				alu_b = 32'd0;
			end
		endcase
	end

	tiht_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	always_comb begin
		tbl_en    = 1'b0;
		tbl_we    = 1'b0;
		tbl_addr  = AW'(base_q + AW'(idx_q));
		tbl_wdata = '{valid: 1'b1, tag: item_q.tick, payload: pay_q};
		case (state_q)
			ST_CLEAR: begin
				tbl_en    = 1'b1;
				tbl_we    = 1'b1;
				tbl_addr  = clr_q;
				tbl_wdata = '0;
			end
			ST_RD: begin
				tbl_en = 1'b1;
			end
			ST_WR: begin
				tbl_en   = 1'b1;
				tbl_we   = 1'b1;
				tbl_addr = AW'(base_q + AW'(idx0_q));
			end
			default: begin
				tbl_en = 1'b0;
			end
		endcase
	end

	tiht_table #(
		.DEPTH (TABLE),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.en    (tbl_en),
		.we    (tbl_we),
		.addr  (tbl_addr),
		.wdata (tbl_wdata),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_q           <= '0;
			slot_count_q    <= 4'd1;
			invent_total_q  <= '0;
			promote_total_q <= '0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				slot_count_q <= cfg_sat;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == AW'(TABLE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (reject) begin
							state_q <= ST_DONE;
						end else if (DEPTH_POW2) begin
							state_q <= ST_DISPATCH;
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					state_q <= ST_MODSUB;
				end
				ST_MODSUB: begin
					state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					case (item_q.kind)
						KIND_GET:  state_q <= ST_RD;
						KIND_HOLD: state_q <= ST_STEP;
						default:   state_q <= ST_WR;
					endcase
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (item_q.kind == KIND_GET) begin
						state_q <= ST_DONE;
					end else if (hit) begin
						state_q <= ST_WR;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if ((back_q == RW'(HIST_DEPTH - 1)) || (cur_q == 32'd0)) begin
						state_q <= ST_WR;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_WR: begin
					if ((item_q.kind == KIND_HOLD) || (item_q.kind == KIND_IDLE)) begin
						invent_total_q <= invent_total_q + 32'd1;
					end
					if (item_q.kind == KIND_PROMOTE) begin
						promote_total_q <= promote_total_q + 32'd1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q     <= req;
					base_q     <= AW'(32'(req.slot) * 32'(HIST_DEPTH));
					cur_q      <= req.tick;
					back_q     <= '0;
					idx0_q     <= req.tick[RW-1:0];
					idx_q      <= req.tick[RW-1:0];
					res_ok_q   <= 1'b0;
					res_show_q <= 1'b0;
				end
			end
			ST_MOD: begin
				quot_q <= 32'(recip_prod >> RS);
			end
			ST_MODSUB: begin
				idx0_q <= alu.diff[RW-1:0];
				idx_q  <= alu.diff[RW-1:0];
			end
			ST_DISPATCH: begin
				case (item_q.kind)
					KIND_PUT, KIND_PROMOTE: begin
						pay_q.buttons   <= item_q.buttons;
						pay_q.stick_x   <= item_q.stick_x;
						pay_q.stick_y   <= item_q.stick_y;
						pay_q.analog    <= item_q.analog;
						pay_q.predicted <= (item_q.kind == KIND_PUT) ? item_q.predicted : 1'b0;
					end
					default: begin
						pay_q <= IDLE_PAYLOAD;
					end
				endcase
			end
			ST_CHK: begin
				if (hit) begin
					pay_q <= {(item_q.kind != KIND_GET) || tbl_rdata.payload.predicted,
						tbl_rdata.payload[32:0]};
					if (item_q.kind == KIND_GET) begin
						res_ok_q   <= 1'b1;
						res_show_q <= 1'b1;
					end
				end
			end
			ST_STEP: begin
				cur_q  <= alu.diff;
				back_q <= RW'(back_q + 1'b1);
				idx_q  <= (idx_q == '0) ? RW'(HIST_DEPTH - 1) : RW'(idx_q - 1'b1);
			end
			ST_WR: begin
				res_ok_q   <= 1'b1;
				res_show_q <= (item_q.kind == KIND_HOLD) || (item_q.kind == KIND_IDLE);
			end
			ST_DONE: begin
				if (rsp_load) begin
					rsp_q.ok            <= res_ok_q;
					rsp_q.out_tick      <= res_show_q ? item_q.tick : 32'd0;
					rsp_q.out_buttons   <= res_show_q ? pay_q.buttons : 16'd0;
					rsp_q.out_stick_x   <= res_show_q ? pay_q.stick_x : 8'sd0;
					rsp_q.out_stick_y   <= res_show_q ? pay_q.stick_y : 8'sd0;
					rsp_q.out_analog    <= res_show_q && pay_q.analog;
					rsp_q.out_predicted <= res_show_q && pay_q.predicted;
					rsp_q.invents_done  <= invent_total_q;
					rsp_q.promotes_done <= promote_total_q;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// An accepted request leaves the sequencer busy in the cycle after its accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after an accepted request");

	// No result is offered before the table has been cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !rsp_valid_q)
		else $error("result offered during the clearing pass");

	// The counters move only when a table write completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WR) |=> ($stable(invent_total_q) && $stable(promote_total_q)))
		else $error("counter moved outside a table write");

	// A successful put or promote always carried a valid frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && res_ok_q &&
			((item_q.kind == KIND_PUT) || (item_q.kind == KIND_PROMOTE))) |-> item_q.frame_valid)
		else $error("invalid frame reported as stored");

	// The reciprocal quotient never exceeds the true quotient of the tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MODSUB) |-> !alu.borrow)
		else $error("ring position underflowed");

endmodule
